@@ rtl/thh_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Token hash histogram package
// Item types, command and status bundles, state codes and the hash round.
// ============================================================================
package thh_pkg;

    localparam int BIN_BITS_DEFAULT = 12;
    localparam int TOKEN_W          = 32;
    localparam int COUNT_W          = 32;
    localparam int IDX_OUT_W        = 12;
    localparam int HASH_ROUNDS      = 4;
    localparam int ROUND_W          = 2;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic                      command;
        logic signed [TOKEN_W-1:0] token;
        logic [IDX_OUT_W-1:0]      read_bin;
    } in_item_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] bin_index;
        logic [COUNT_W-1:0]   bin_count;
        logic                 counted;
    } out_item_t;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_HASH   = 6'b000100,
        ST_READ   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic hash_step;
        logic mem_read;
        logic mem_update;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic new_read;
        logic new_pos;
        logic hash_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [TOKEN_W-1:0] mix_round(input logic [TOKEN_W-1:0] h,
                                                     input logic [ROUND_W-1:0] r);
        logic [TOKEN_W-1:0] a;
        logic [TOKEN_W-1:0] x;
        a = h;
        x = h;
        case (r)
            2'd0:
            begin
                a = h + (h << 12);
                x = a ^ TOKEN_W'($signed(a) >>> 22);
            end
            2'd1:
            begin
                a = h + (h << 4);
                x = a ^ TOKEN_W'($signed(a) >>> 9);
            end
            2'd2:
            begin
                a = h + (h << 10);
                x = a ^ TOKEN_W'($signed(a) >>> 2);
            end
            default:
            begin
                a = h + (h << 7);
                x = a ^ TOKEN_W'($signed(a) >>> 12);
            end
        endcase
        return x;
    endfunction

endpackage

@@ rtl/thh_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Token hash histogram controller
// Sequences clearing, hashing, bin read, bin update and result hand-off.
// ============================================================================
module thh_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  thh_pkg::dp_status_t sts,
    output thh_pkg::ctrl_cmd_t  cmd
);

    thh_pkg::state_t state_reg;
    thh_pkg::state_t state_next;
    logic            idle;

    assign idle     = (state_reg == thh_pkg::ST_IDLE);
    assign in_stall = !idle;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            thh_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = thh_pkg::ST_IDLE;
                end
            end
            thh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.new_read)
                    begin
                        state_next = thh_pkg::ST_READ;
                    end
                    else if (sts.new_pos)
                    begin
                        state_next = thh_pkg::ST_HASH;
                    end
                    else
                    begin
                        state_next = thh_pkg::ST_OUT;
                    end
                end
            end
            thh_pkg::ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last)
                begin
                    state_next = thh_pkg::ST_READ;
                end
            end
            thh_pkg::ST_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = thh_pkg::ST_UPDATE;
            end
            thh_pkg::ST_UPDATE:
            begin
                cmd.mem_update = 1'b1;
                state_next     = thh_pkg::ST_OUT;
            end
            thh_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = thh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = thh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= thh_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/thh_datapath.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Token hash histogram datapath
// Item register, iterative hash, bin store, saturating update, result register.
// ============================================================================
module thh_datapath #(
    parameter int BIN_BITS = thh_pkg::BIN_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  thh_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output thh_pkg::out_item_t  out_item,
    input  thh_pkg::ctrl_cmd_t  cmd,
    output thh_pkg::dp_status_t sts
);

    localparam int DEPTH = 1 << BIN_BITS;

    logic [thh_pkg::COUNT_W-1:0] mem [DEPTH];

    logic [BIN_BITS-1:0]          clr_addr_reg;
    thh_pkg::in_item_t            item_reg;
    logic [thh_pkg::TOKEN_W-1:0]  hash_reg;
    logic [thh_pkg::ROUND_W-1:0]  round_reg;
    logic [BIN_BITS-1:0]          idx_reg;
    logic [thh_pkg::COUNT_W-1:0]  rdata_reg;
    thh_pkg::out_item_t           res_reg;
    thh_pkg::out_item_t           out_reg;
    logic                         out_valid_reg;

    logic [BIN_BITS-1:0]          rd_idx;
    logic [thh_pkg::COUNT_W-1:0]  inc_value;
    logic                         is_read;

    assign is_read   = (item_reg.command == thh_pkg::CMD_READ);
    assign rd_idx    = is_read ? BIN_BITS'(item_reg.read_bin) : hash_reg[BIN_BITS-1:0];
    assign inc_value = (rdata_reg == '1) ? rdata_reg : rdata_reg + 1'b1;

    assign sts.clear_last = (clr_addr_reg == '1);
    assign sts.new_read   = (in_item.command == thh_pkg::CMD_READ);
    assign sts.new_pos    = !in_item.token[thh_pkg::TOKEN_W-1] && (in_item.token != '0);
    assign sts.hash_last  = (round_reg == thh_pkg::ROUND_W'(thh_pkg::HASH_ROUNDS - 1));
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                round_reg <= '0;
            end
            else if (cmd.hash_step)
            begin
                round_reg <= round_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_item;
            hash_reg <= in_item.token;
            res_reg  <= '0;
        end
        else
        begin
            if (cmd.hash_step)
            begin
                hash_reg <= thh_pkg::mix_round(hash_reg, round_reg);
            end
            if (cmd.mem_update)
            begin
                res_reg.bin_index <= thh_pkg::IDX_OUT_W'(idx_reg);
                res_reg.bin_count <= is_read ? rdata_reg : inc_value;
                res_reg.counted   <= !is_read;
            end
        end
        if (cmd.mem_read)
        begin
            idx_reg <= rd_idx;
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.mem_update && !is_read)
        begin
            mem[idx_reg] <= inc_value;
        end
        if (cmd.mem_read)
        begin
            rdata_reg <= mem[rd_idx];
        end
    end

endmodule

@@ rtl/token_hash_histogram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Token hash histogram
// Hashes positive tokens into 2^BIN_BITS saturating 32-bit bins; reads bins.
// ============================================================================
// A counted token passes through 4 hash rounds, bin read, bin update and result
// load; a read skips the hash rounds, and an ignored token goes straight to result load.
// Only one item is in flight at a time: in_stall stays high until the result is
// loaded; the shared hash round and the single-port bin store are used in turn.
// Reset: a clearing pass over all 2^BIN_BITS bins zeroes them; stall stays high.
module token_hash_histogram #(
    parameter int BIN_BITS = thh_pkg::BIN_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  thh_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output thh_pkg::out_item_t out_item
);

    thh_pkg::ctrl_cmd_t  cmd;
    thh_pkg::dp_status_t sts;

    thh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    thh_datapath #(
        .BIN_BITS (BIN_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while previous item in flight");

    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.counted |-> out_item.bin_count != '0)
        else $error("counted item reports zero bin count");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || !out_stall))
        else $error("result overwritten before it was taken");

endmodule

@@ bench/tb_token_hash_histogram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Token hash histogram testbench
// A directed table (reads after reset, ignored tokens, extreme tokens), then
// about 2000 random count and read items, some drawn from a small token pool so
// that bins climb. Every result is checked field by field, against the table's
// typed result or else a local model of the hash and the saturating bins. Both
// sides idle at random, except during one quiet stretch.
// ============================================================================
module tb_token_hash_histogram;

    localparam int BIN_BITS     = thh_pkg::BIN_BITS_DEFAULT;
    localparam int NUM_BINS     = 1 << BIN_BITS;
    localparam int RANDOM_ITEMS = 2000;
    localparam int IDLE_PCT     = 9;
    localparam int POOL_SIZE    = 16;
    localparam int HIT_DEPTH    = 64;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        thh_pkg::in_item_t  item;
        bit                 typed;
        thh_pkg::out_item_t result;
    } dir_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    thh_pkg::in_item_t  in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    thh_pkg::out_item_t out_item;

    logic [thh_pkg::COUNT_W-1:0]   bin_counts [NUM_BINS];
    thh_pkg::out_item_t            expected_results [$];
    logic [thh_pkg::IDX_OUT_W-1:0] hit_bins [$];
    int                            idle_pct    = IDLE_PCT;
    int                            errors      = 0;
    int                            cycle_count = 0;

    token_hash_histogram #(
        .BIN_BITS(BIN_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] arith_shr(input logic [31:0] v, input int unsigned n);
        logic signed [31:0] s;
        s = v;
        return s >>> n;
    endfunction

    function automatic logic [31:0] token_mix(input logic [31:0] v);
        logic [31:0] h;
        h = v;
        h = h + (h << 12);
        h = h ^ arith_shr(h, 22);
        h = h + (h << 4);
        h = h ^ arith_shr(h, 9);
        h = h + (h << 10);
        h = h ^ arith_shr(h, 2);
        h = h + (h << 7);
        h = h ^ arith_shr(h, 12);
        return h;
    endfunction

    function automatic thh_pkg::out_item_t predict_item(input thh_pkg::in_item_t item);
        thh_pkg::out_item_t  res;
        logic [BIN_BITS-1:0] bin;
        logic [31:0]         mixed;
        res = '0;
        if (item.command == thh_pkg::CMD_READ)
        begin
            bin = item.read_bin[BIN_BITS-1:0];
            res.bin_index = thh_pkg::IDX_OUT_W'(bin);
            res.bin_count = bin_counts[bin];
        end
        else if (!item.token[thh_pkg::TOKEN_W-1] && item.token != '0)
        begin
            mixed = token_mix(item.token);
            bin = mixed[BIN_BITS-1:0];
            if (bin_counts[bin] != '1)
                bin_counts[bin] = bin_counts[bin] + 1'b1;
            res.bin_index = thh_pkg::IDX_OUT_W'(bin);
            res.bin_count = bin_counts[bin];
            res.counted   = 1'b1;
        end
        return res;
    endfunction

    task automatic send_item(input thh_pkg::in_item_t item, input bit typed,
                             input thh_pkg::out_item_t typed_res);
        thh_pkg::out_item_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_item(item);
        if (predicted.counted)
        begin
            hit_bins.push_back(predicted.bin_index);
            if (hit_bins.size() > HIT_DEPTH)
                void'(hit_bins.pop_front());
        end
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL token_hash_histogram");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_check
        thh_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected item bin_index=%0d bin_count=%0d counted=%0b",
                         $time, out_item.bin_index, out_item.bin_count, out_item.counted);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_item.bin_index != want.bin_index)
                begin
                    $display("%0t: bin_index expected %0d actual %0d",
                             $time, want.bin_index, out_item.bin_index);
                    errors++;
                end
                if (out_item.bin_count != want.bin_count)
                begin
                    $display("%0t: bin_count expected %0d actual %0d",
                             $time, want.bin_count, out_item.bin_count);
                    errors++;
                end
                if (out_item.counted != want.counted)
                begin
                    $display("%0t: counted expected %0b actual %0b",
                             $time, want.counted, out_item.counted);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t                    dir_rows [$];
        logic [thh_pkg::TOKEN_W-1:0] token_pool [POOL_SIZE];
        thh_pkg::in_item_t           item;
        int                          pick;

        foreach (bin_counts[i])
            bin_counts[i] = '0;
        foreach (token_pool[i])
            token_pool[i] = $urandom_range(1, 32'h7FFF_FFFF);

        dir_rows.push_back('{'{thh_pkg::CMD_READ,  32'h0000_0000, 12'h000}, 1'b1,
                             '{12'h000, 32'd0, 1'b0}});
        dir_rows.push_back('{'{thh_pkg::CMD_READ,  32'hFFFF_FFFF, 12'hFFF}, 1'b1,
                             '{12'hFFF, 32'd0, 1'b0}});
        dir_rows.push_back('{'{thh_pkg::CMD_READ,  32'h7FFF_FFFF, 12'hAAA}, 1'b1,
                             '{12'hAAA, 32'd0, 1'b0}});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'h0000_0000, 12'h000}, 1'b1,
                             '{12'h000, 32'd0, 1'b0}});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'h8000_0000, 12'hFFF}, 1'b1,
                             '{12'h000, 32'd0, 1'b0}});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'hFFFF_FFFF, 12'h555}, 1'b1,
                             '{12'h000, 32'd0, 1'b0}});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'hAAAA_AAAA, 12'h000}, 1'b1,
                             '{12'h000, 32'd0, 1'b0}});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'h0000_0001, 12'h000}, 1'b0, '0});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'h0000_0001, 12'hFFF}, 1'b0, '0});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'h7FFF_FFFF, 12'h000}, 1'b0, '0});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'h7FFF_FFFF, 12'h000}, 1'b0, '0});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'h4000_0000, 12'h000}, 1'b0, '0});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'h5555_5555, 12'h000}, 1'b0, '0});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'h2AAA_AAAA, 12'h000}, 1'b0, '0});
        dir_rows.push_back('{'{thh_pkg::CMD_COUNT, 32'h0000_0002, 12'h000}, 1'b0, '0});
        dir_rows.push_back('{'{thh_pkg::CMD_READ,  32'h8000_0000, 12'h555}, 1'b0, '0});
        dir_rows.push_back('{'{thh_pkg::CMD_READ,  32'h0000_0001, 12'hAAA}, 1'b0, '0});
        dir_rows.push_back('{'{thh_pkg::CMD_READ,  32'h0000_0000, 12'h001}, 1'b0, '0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].result);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_pct = (n >= 800 && n < 1200) ? 0 : IDLE_PCT;
            pick = $urandom_range(0, 99);
            item.command  = thh_pkg::CMD_COUNT;
            item.token    = $urandom();
            item.read_bin = thh_pkg::IDX_OUT_W'($urandom_range(0, NUM_BINS - 1));
            if (pick < 30)
                item.token = token_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick < 55)
            begin
                item.token[thh_pkg::TOKEN_W-1] = 1'b0;
                if (item.token == '0)
                    item.token = 1;
            end
            else if (pick < 70)
            begin
                if ($urandom_range(0, 3) == 0)
                    item.token = '0;
                else
                    item.token[thh_pkg::TOKEN_W-1] = 1'b1;
            end
            else
            begin
                item.command = thh_pkg::CMD_READ;
                if (hit_bins.size() != 0 && $urandom_range(0, 1) == 1)
                    item.read_bin = hit_bins[$urandom_range(0, hit_bins.size() - 1)];
            end
            send_item(item, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS token_hash_histogram");
        else
            $display("FAIL token_hash_histogram");
        $finish;
    end

endmodule

@@ files.f @@
rtl/thh_pkg.sv
rtl/thh_ctrl.sv
rtl/thh_datapath.sv
rtl/token_hash_histogram.sv
bench/tb_token_hash_histogram.sv
